>>> hdl/cfpc_pkg.sv
`timescale 1ns / 1ps

package cfpc_pkg;

  // Largest payload length that the checker accepts.
  localparam int unsigned MAX_PAYLOAD = 1016;
  localparam int unsigned POS_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Output tdata: payload_byte, payload_index, command_code, frame_length,
  // frame_status, padded with zeros to whole bytes.
  localparam int unsigned OUT_FIELDS_W = BYTE_W + INDEX_W + BYTE_W + LEN_W + STATUS_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HIGH = 2'd0,
    REG_START_LOW  = 2'd1,
    REG_STOP_HIGH  = 2'd2,
    REG_STOP_LOW   = 2'd3
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BAD_STOP  = 3'd3,
    ST_BAD_SUM   = 3'd4
  } frame_status_t;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_START_L = 8'b0000_0010,
    PH_CMD     = 8'b0000_0100,
    PH_LEN     = 8'b0000_1000,
    PH_PAYLOAD = 8'b0001_0000,
    PH_CSUM    = 8'b0010_0000,
    PH_STOP_H  = 8'b0100_0000,
    PH_STOP_L  = 8'b1000_0000
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_t;

  // Marker bytes programmed through the configuration port.
  typedef struct packed {
    logic [BYTE_W-1:0] start_high;
    logic [BYTE_W-1:0] start_low;
    logic [BYTE_W-1:0] stop_high;
    logic [BYTE_W-1:0] stop_low;
  } markers_t;

  typedef struct packed {
    logic                valid;
    result_kind_t        kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [INDEX_W-1:0]  payload_index;
    logic [BYTE_W-1:0]   command_code;
    logic [LEN_W-1:0]    frame_length;
    frame_status_t       frame_status;
  } result_t;

endpackage

>>> hdl/cfpc_cfg.sv
`timescale 1ns / 1ps

// Holds the four marker bytes written over the configuration port.
module cfpc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [cfpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [cfpc_pkg::BYTE_W-1:0]    wr_data,
  output cfpc_pkg::markers_t             markers
);

  cfpc_pkg::markers_t markers_r;
  cfpc_pkg::markers_t markers_nxt;

  always_comb begin
    markers_nxt = markers_r;
    if (wr_en) begin
      case (cfpc_pkg::cfg_reg_t'(wr_index))
        cfpc_pkg::REG_START_HIGH: markers_nxt.start_high = wr_data;
        cfpc_pkg::REG_START_LOW:  markers_nxt.start_low  = wr_data;
        cfpc_pkg::REG_STOP_HIGH:  markers_nxt.stop_high  = wr_data;
        cfpc_pkg::REG_STOP_LOW:   markers_nxt.stop_low   = wr_data;
        default:                  markers_nxt = markers_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      markers_r <= '0;
    end else begin
      markers_r <= markers_nxt;
    end
  end

  assign markers = markers_r;

endmodule

>>> hdl/cfpc_parser.sv
`timescale 1ns / 1ps

// Frame parser: per-byte state update and the result for that byte.
module cfpc_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [cfpc_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        first_of_packet,
  input  cfpc_pkg::markers_t          markers,
  output cfpc_pkg::result_t           result
);

  cfpc_pkg::phase_t                 phase_r, phase_nxt;
  logic                             len_sel_r, len_sel_nxt;
  logic [cfpc_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [cfpc_pkg::LEN_W-1:0]       length_r, length_nxt;
  logic [cfpc_pkg::BYTE_W-1:0]      command_r, command_nxt;
  logic [cfpc_pkg::BYTE_W-1:0]      sum_r, sum_nxt;
  logic                             sum_ok_r, sum_ok_nxt;
  logic                             stop_h_ok_r, stop_h_ok_nxt;
  logic [cfpc_pkg::POS_W-1:0]       pos_inc;
  logic [cfpc_pkg::LEN_W-1:0]       full_length;
  cfpc_pkg::result_t                res;

  assign pos_inc     = pos_r + 1'b1;
  assign full_length = {length_r[cfpc_pkg::LEN_W-1:cfpc_pkg::BYTE_W], rx_byte};

  always_comb begin
    phase_nxt     = phase_r;
    len_sel_nxt   = len_sel_r;
    pos_nxt       = pos_r;
    length_nxt    = length_r;
    command_nxt   = command_r;
    sum_nxt       = sum_r;
    sum_ok_nxt    = sum_ok_r;
    stop_h_ok_nxt = stop_h_ok_r;

    res               = '0;
    res.kind          = cfpc_pkg::KIND_VERDICT;
    res.command_code  = command_r;
    res.frame_length  = length_r;
    res.frame_status  = cfpc_pkg::ST_OK;

    if (first_of_packet) begin
      // A new packet always restarts the frame, dropping any open one.
      len_sel_nxt   = 1'b0;
      pos_nxt       = '0;
      length_nxt    = '0;
      command_nxt   = '0;
      sum_ok_nxt    = 1'b0;
      stop_h_ok_nxt = 1'b0;
      sum_nxt       = rx_byte;
      if (rx_byte != markers.start_high) begin
        res.valid        = 1'b1;
        res.command_code = '0;
        res.frame_length = '0;
        res.frame_status = cfpc_pkg::ST_BAD_START;
        phase_nxt        = cfpc_pkg::PH_IDLE;
      end else begin
        phase_nxt = cfpc_pkg::PH_START_L;
      end
    end else begin
      case (phase_r)
        cfpc_pkg::PH_START_L: begin
          sum_nxt = sum_r + rx_byte;
          if (rx_byte != markers.start_low) begin
            res.valid        = 1'b1;
            res.command_code = '0;
            res.frame_length = '0;
            res.frame_status = cfpc_pkg::ST_BAD_START;
            phase_nxt        = cfpc_pkg::PH_IDLE;
          end else begin
            phase_nxt = cfpc_pkg::PH_CMD;
          end
        end
        cfpc_pkg::PH_CMD: begin
          sum_nxt     = sum_r + rx_byte;
          command_nxt = rx_byte;
          len_sel_nxt = 1'b0;
          phase_nxt   = cfpc_pkg::PH_LEN;
        end
        cfpc_pkg::PH_LEN: begin
          sum_nxt = sum_r + rx_byte;
          if (!len_sel_r) begin
            length_nxt  = {rx_byte, {cfpc_pkg::BYTE_W{1'b0}}};
            len_sel_nxt = 1'b1;
          end else begin
            length_nxt  = full_length;
            len_sel_nxt = 1'b0;
            pos_nxt     = '0;
            if (full_length > cfpc_pkg::LEN_W'(cfpc_pkg::MAX_PAYLOAD)) begin
              res.valid        = 1'b1;
              res.frame_length = full_length;
              res.frame_status = cfpc_pkg::ST_TOO_LONG;
              phase_nxt        = cfpc_pkg::PH_IDLE;
            end else if (full_length == '0) begin
              phase_nxt = cfpc_pkg::PH_CSUM;
            end else begin
              phase_nxt = cfpc_pkg::PH_PAYLOAD;
            end
          end
        end
        cfpc_pkg::PH_PAYLOAD: begin
          sum_nxt           = sum_r + rx_byte;
          res.valid         = 1'b1;
          res.kind          = cfpc_pkg::KIND_PAYLOAD;
          res.payload_byte  = rx_byte;
          res.payload_index = cfpc_pkg::INDEX_W'(pos_r);
          pos_nxt           = pos_inc;
          if (cfpc_pkg::LEN_W'(pos_inc) >= length_r) begin
            phase_nxt = cfpc_pkg::PH_CSUM;
          end
        end
        cfpc_pkg::PH_CSUM: begin
          sum_ok_nxt = (rx_byte == sum_r);
          phase_nxt  = cfpc_pkg::PH_STOP_H;
        end
        cfpc_pkg::PH_STOP_H: begin
          stop_h_ok_nxt = (rx_byte == markers.stop_high);
          phase_nxt     = cfpc_pkg::PH_STOP_L;
        end
        cfpc_pkg::PH_STOP_L: begin
          // A stop mismatch outranks a checksum mismatch.
          res.valid = 1'b1;
          phase_nxt = cfpc_pkg::PH_IDLE;
          if (!stop_h_ok_r || rx_byte != markers.stop_low) begin
            res.frame_status = cfpc_pkg::ST_BAD_STOP;
          end else if (!sum_ok_r) begin
            res.frame_status = cfpc_pkg::ST_BAD_SUM;
          end else begin
            res.frame_status = cfpc_pkg::ST_OK;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cfpc_pkg::PH_IDLE;
      len_sel_r   <= 1'b0;
      pos_r       <= '0;
      length_r    <= '0;
      command_r   <= '0;
      sum_r       <= '0;
      sum_ok_r    <= 1'b0;
      stop_h_ok_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      len_sel_r   <= len_sel_nxt;
      pos_r       <= pos_nxt;
      length_r    <= length_nxt;
      command_r   <= command_nxt;
      sum_r       <= sum_nxt;
      sum_ok_r    <= sum_ok_nxt;
      stop_h_ok_r <= stop_h_ok_nxt;
    end
  end

  assign result = res;

endmodule

>>> hdl/checksum_framed_packet_checker.sv
`timescale 1ns / 1ps

// Length-framed packet checker. Received bytes arrive one per request on the
// input stream, with in_tuser set on the first byte of each packet. A frame is
// two start bytes, a command byte, a big-endian 16-bit length, the payload, an
// 8-bit wrap-around sum of all bytes before it, and two stop bytes directly
// after the checksum. Each payload byte is forwarded at once as a tentative
// result (out_tuser low) with its index; a frame ends in one verdict
// (out_tuser high) carrying command, length and a status of ok, bad start,
// too long (above 1016 bytes), bad stop or bad checksum. A stop error is
// reported in preference to a checksum error. A first-of-packet byte in the
// middle of a frame abandons that frame without a verdict. The block takes one
// byte per clock cycle while results are taken; a byte goes through an input
// register and the parser logic into the output register before its result is
// offered. Marker bytes are written over the cfg port, which is always ready,
// and must only be changed while no frame is in flight.
module checksum_framed_packet_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cfpc_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  input  logic                                in_tuser,   // [0] first_of_packet
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] payload_byte, [17:8] payload_index, [25:18] command_code,
  // [41:26] frame_length, [44:42] frame_status, [47:45] zero
  output logic [cfpc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser,  // [0] result_kind
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cfpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfpc_pkg::BYTE_W-1:0]         cfg_data
);

  localparam int unsigned PAD_W = cfpc_pkg::OUT_DATA_W - cfpc_pkg::OUT_FIELDS_W;

  cfpc_pkg::markers_t              markers;
  cfpc_pkg::result_t               result;

  // Input register.
  logic                            s1_valid_r, s1_valid_nxt;
  logic [cfpc_pkg::BYTE_W-1:0]     s1_byte_r;
  logic                            s1_first_r;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic [cfpc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                            out_kind_r, out_kind_nxt;

  logic                            in_fire;
  logic                            s1_fire;
  logic                            s2_ready;

  // The output register frees up when it is empty or its result is taken,
  // so a new byte can enter every cycle while the consumer keeps up.
  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  cfpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .markers  (markers)
  );

  cfpc_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (s1_fire),
    .rx_byte         (s1_byte_r),
    .first_of_packet (s1_first_r),
    .markers         (markers),
    .result          (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    if (s2_ready) begin
      out_valid_nxt = s1_fire && result.valid;
      out_data_nxt  = {{PAD_W{1'b0}},
                       result.frame_status,
                       result.frame_length,
                       result.command_code,
                       result.payload_index,
                       result.payload_byte};
      out_kind_nxt  = result.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_tdata;
      s1_first_r <= in_tuser;
    end
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

>>> bench/checksum_framed_packet_checker_test.sv
`timescale 1ns / 1ps

// Bench for the length-framed packet checker.
//
// A byte backlog is filled by the stimulus process and drained by a driver
// that changes the input stream on the falling clock edge. A monitor on the
// rising edge sees every accepted request on both streams. An accepted input
// byte is run through a cycle-free frame parser kept in this bench, and any
// result it yields is queued. An accepted output result is compared field by
// field with the oldest queued one.
module checksum_framed_packet_checker_test;

  localparam int unsigned IDX_LO = cfpc_pkg::BYTE_W;
  localparam int unsigned CMD_LO = IDX_LO + cfpc_pkg::INDEX_W;
  localparam int unsigned LEN_LO = CMD_LO + cfpc_pkg::BYTE_W;
  localparam int unsigned ST_LO  = LEN_LO + cfpc_pkg::LEN_W;
  localparam int unsigned PAD_LO = ST_LO + cfpc_pkg::STATUS_W;

  // A byte goes through two register stages, so the settle wait covers
  // any work still going on once the last result has been taken.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned GAP_MAX       = 19;

  typedef struct packed {
    logic [cfpc_pkg::BYTE_W-1:0] data;
    logic                        first;
  } rx_item_t;

  // Ways in which a generated frame departs from a well-formed one.
  typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_STOP_H,
    FLAW_STOP_L,
    FLAW_STOP_SUM,
    FLAW_START_H,
    FLAW_START_L,
    FLAW_CUT
  } flaw_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [cfpc_pkg::BYTE_W-1:0]     in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cfpc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [cfpc_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [cfpc_pkg::BYTE_W-1:0]     cfg_data   = '0;

  checksum_framed_packet_checker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be sent, and results the parser says must come out.
  rx_item_t          rx_backlog[$];
  cfpc_pkg::result_t results_due[$];

  // Parser state, a mirror of what the block should hold.
  cfpc_pkg::markers_t          markers;
  cfpc_pkg::phase_t            p_phase;
  logic [15:0]                 p_pos;
  logic [cfpc_pkg::LEN_W-1:0]  p_len;
  logic [cfpc_pkg::BYTE_W-1:0] p_cmd;
  logic [cfpc_pkg::BYTE_W-1:0] p_csum;
  logic                        p_csum_ok;
  logic                        p_stop_h_ok;

  // Handshake bookkeeping used by the driver and the monitor.
  rx_item_t    cur_rx;
  bit          in_pending = 1'b0;
  int unsigned in_gap     = 0;
  int unsigned out_stall  = 0;
  bit          in_calm    = 1'b0;
  bit          out_calm   = 1'b0;

  int unsigned errors        = 0;
  int unsigned bytes_queued  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned payloads_seen = 0;
  int unsigned frames_built  = 0;
  int unsigned settings_used = 1;
  int unsigned status_seen[5];

  // Frame parser. Called once for every accepted input byte; a byte yields
  // at most one result, which goes to the back of results_due.
  task automatic parse_rx_byte(input logic [cfpc_pkg::BYTE_W-1:0] b, input logic first);
    cfpc_pkg::result_t r;
    bit                emit;
    r       = '0;
    r.valid = 1'b1;
    emit    = 1'b0;
    if (first) begin
      // A first byte always restarts the parser, whatever was in flight.
      p_pos       = '0;
      p_len       = '0;
      p_cmd       = '0;
      p_csum_ok   = 1'b0;
      p_stop_h_ok = 1'b0;
      p_csum      = b;
      if (b != markers.start_high) begin
        r.kind         = cfpc_pkg::KIND_VERDICT;
        r.frame_status = cfpc_pkg::ST_BAD_START;
        emit           = 1'b1;
        p_phase        = cfpc_pkg::PH_IDLE;
      end else begin
        p_phase = cfpc_pkg::PH_START_L;
      end
    end else begin
      case (p_phase)
        cfpc_pkg::PH_START_L: begin
          p_csum = p_csum + b;
          if (b != markers.start_low) begin
            r.kind         = cfpc_pkg::KIND_VERDICT;
            r.frame_status = cfpc_pkg::ST_BAD_START;
            emit           = 1'b1;
            p_phase        = cfpc_pkg::PH_IDLE;
          end else begin
            p_phase = cfpc_pkg::PH_CMD;
          end
        end
        cfpc_pkg::PH_CMD: begin
          p_csum  = p_csum + b;
          p_cmd   = b;
          p_pos   = '0;
          p_phase = cfpc_pkg::PH_LEN;
        end
        cfpc_pkg::PH_LEN: begin
          p_csum = p_csum + b;
          if (p_pos == 0) begin
            p_len = {b, 8'h00};
            p_pos = 1;
          end else begin
            p_len = p_len | cfpc_pkg::LEN_W'(b);
            p_pos = '0;
            if (p_len > cfpc_pkg::MAX_PAYLOAD) begin
              r.kind         = cfpc_pkg::KIND_VERDICT;
              r.command_code = p_cmd;
              r.frame_length = p_len;
              r.frame_status = cfpc_pkg::ST_TOO_LONG;
              emit           = 1'b1;
              p_phase        = cfpc_pkg::PH_IDLE;
            end else begin
              p_phase = (p_len == 0) ? cfpc_pkg::PH_CSUM : cfpc_pkg::PH_PAYLOAD;
            end
          end
        end
        cfpc_pkg::PH_PAYLOAD: begin
          // Every payload byte is passed on at once with its position.
          p_csum          = p_csum + b;
          r.kind          = cfpc_pkg::KIND_PAYLOAD;
          r.payload_byte  = b;
          r.payload_index = p_pos[cfpc_pkg::INDEX_W-1:0];
          r.command_code  = p_cmd;
          r.frame_length  = p_len;
          r.frame_status  = cfpc_pkg::ST_OK;
          emit            = 1'b1;
          p_pos           = p_pos + 1;
          if (p_pos >= p_len) p_phase = cfpc_pkg::PH_CSUM;
        end
        cfpc_pkg::PH_CSUM: begin
          p_csum_ok = (b == p_csum);
          p_phase   = cfpc_pkg::PH_STOP_H;
        end
        cfpc_pkg::PH_STOP_H: begin
          p_stop_h_ok = (b == markers.stop_high);
          p_phase     = cfpc_pkg::PH_STOP_L;
        end
        cfpc_pkg::PH_STOP_L: begin
          // A stop error hides a checksum error.
          r.kind         = cfpc_pkg::KIND_VERDICT;
          r.command_code = p_cmd;
          r.frame_length = p_len;
          if (!p_stop_h_ok || b != markers.stop_low) r.frame_status = cfpc_pkg::ST_BAD_STOP;
          else if (!p_csum_ok)                       r.frame_status = cfpc_pkg::ST_BAD_SUM;
          else                                       r.frame_status = cfpc_pkg::ST_OK;
          emit    = 1'b1;
          p_phase = cfpc_pkg::PH_IDLE;
        end
        default: begin
          // Bytes outside a frame without the first flag are dropped.
        end
      endcase
    end
    if (emit) results_due.push_back(r);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: mismatch in %s, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input logic kind, input logic [cfpc_pkg::OUT_DATA_W-1:0] d);
    cfpc_pkg::result_t want;
    if (results_due.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual kind %0b data 0x%0h",
               $time, kind, d);
      errors++;
    end else begin
      want = results_due.pop_front();
      compare_field("result_kind", want.kind, kind);
      compare_field("payload_byte", want.payload_byte, d[0 +: cfpc_pkg::BYTE_W]);
      compare_field("payload_index", want.payload_index, d[IDX_LO +: cfpc_pkg::INDEX_W]);
      compare_field("command_code", want.command_code, d[CMD_LO +: cfpc_pkg::BYTE_W]);
      compare_field("frame_length", want.frame_length, d[LEN_LO +: cfpc_pkg::LEN_W]);
      compare_field("frame_status", want.frame_status, d[ST_LO +: cfpc_pkg::STATUS_W]);
      compare_field("padding", 0, d[cfpc_pkg::OUT_DATA_W-1:PAD_LO]);
      if (want.kind == cfpc_pkg::KIND_VERDICT) status_seen[want.frame_status]++;
      else payloads_seen++;
    end
  endtask

  // Monitor: everything is sampled on the rising edge. After each accepted
  // request the side that sent or took it draws its next pause, and now and
  // then switches between pausing and running flat out.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_rx_byte(cur_rx.data, cur_rx.first);
        bytes_sent++;
        in_pending = 1'b0;
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (out_tvalid && out_tready) begin
        check_result(out_tuser, out_tdata);
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
    end
  end

  // Driver: inputs move on the falling edge only. A byte on offer is held
  // until the monitor has seen it accepted.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_pending) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap--;
        end else if (rx_backlog.size() > 0) begin
          cur_rx     = rx_backlog.pop_front();
          in_pending = 1'b1;
          in_tvalid <= 1'b1;
          in_tdata  <= cur_rx.data;
          in_tuser  <= cur_rx.first;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_rx(input logic [cfpc_pkg::BYTE_W-1:0] data, input logic first);
    rx_item_t item;
    item.data  = data;
    item.first = first;
    rx_backlog.push_back(item);
    bytes_queued++;
  endtask

  // Builds one frame against the current markers. A too-long length ends the
  // frame after the header, since the block drops the rest anyway.
  task automatic queue_frame(input logic [cfpc_pkg::BYTE_W-1:0] cmd,
                             input logic [cfpc_pkg::LEN_W-1:0] len, input flaw_t flaw);
    logic [cfpc_pkg::BYTE_W-1:0] frame[$];
    logic [cfpc_pkg::BYTE_W-1:0] csum;
    int unsigned                 keep;
    frame.push_back(flaw == FLAW_START_H ?
                    markers.start_high ^ cfpc_pkg::BYTE_W'($urandom_range(1, 255)) :
                    markers.start_high);
    frame.push_back(flaw == FLAW_START_L ?
                    markers.start_low ^ cfpc_pkg::BYTE_W'($urandom_range(1, 255)) :
                    markers.start_low);
    frame.push_back(cmd);
    frame.push_back(len[15:8]);
    frame.push_back(len[7:0]);
    if (len <= cfpc_pkg::MAX_PAYLOAD) begin
      repeat (len) frame.push_back(cfpc_pkg::BYTE_W'($urandom));
      csum = '0;
      foreach (frame[i]) csum = csum + frame[i];
      if (flaw == FLAW_SUM || flaw == FLAW_STOP_SUM) begin
        csum = csum ^ cfpc_pkg::BYTE_W'($urandom_range(1, 255));
      end
      frame.push_back(csum);
      frame.push_back(flaw == FLAW_STOP_H ?
                      markers.stop_high ^ cfpc_pkg::BYTE_W'($urandom_range(1, 255)) :
                      markers.stop_high);
      frame.push_back(flaw == FLAW_STOP_L || flaw == FLAW_STOP_SUM ?
                      markers.stop_low ^ cfpc_pkg::BYTE_W'($urandom_range(1, 255)) :
                      markers.stop_low);
    end
    // A cut frame is left open; the next first byte abandons it.
    keep = (flaw == FLAW_CUT) ? $urandom_range(1, frame.size() - 1) : frame.size();
    for (int i = 0; i < keep; i++) push_rx(frame[i], i == 0);
    frames_built++;
  endtask

  // Mostly well-formed frames of short random length, the rest broken frames
  // and loose bytes, until the byte budget is spent.
  task automatic queue_random_traffic(input int unsigned budget);
    int unsigned                 start;
    int unsigned                 pick;
    logic [cfpc_pkg::LEN_W-1:0]  len;
    logic [cfpc_pkg::BYTE_W-1:0] cmd;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(0, 99);
      cmd  = cfpc_pkg::BYTE_W'($urandom);
      case ($urandom_range(0, 19))
        0:       len = cfpc_pkg::LEN_W'($urandom_range(41, 200));
        1, 2, 3: len = cfpc_pkg::LEN_W'($urandom_range(9, 40));
        default: len = cfpc_pkg::LEN_W'($urandom_range(0, 8));
      endcase
      if      (pick < 60) queue_frame(cmd, len, FLAW_NONE);
      else if (pick < 66) queue_frame(cmd, len, FLAW_SUM);
      else if (pick < 70) queue_frame(cmd, len, FLAW_STOP_H);
      else if (pick < 74) queue_frame(cmd, len, FLAW_STOP_L);
      else if (pick < 77) queue_frame(cmd, len, FLAW_STOP_SUM);
      else if (pick < 80) queue_frame(cmd, len, FLAW_START_H);
      else if (pick < 83) queue_frame(cmd, len, FLAW_START_L);
      else if (pick < 87) queue_frame(cmd, len, FLAW_CUT);
      else if (pick < 90) begin
        queue_frame(cmd, cfpc_pkg::LEN_W'($urandom_range(cfpc_pkg::MAX_PAYLOAD + 1, 65535)),
                    FLAW_NONE);
      end else begin
        // Loose bytes; an occasional first flag may open a frame by chance.
        repeat ($urandom_range(1, 6)) begin
          push_rx(cfpc_pkg::BYTE_W'($urandom), $urandom_range(0, 7) == 0);
        end
      end
    end
  endtask

  // Waits until every byte has gone in and every result has come out, then
  // gives the block time to finish a byte that yields nothing.
  task automatic settle();
    while (rx_backlog.size() != 0 || in_pending || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input cfpc_pkg::cfg_reg_t idx,
                              input logic [cfpc_pkg::BYTE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cfpc_pkg::REG_START_HIGH: markers.start_high = value;
      cfpc_pkg::REG_START_LOW:  markers.start_low  = value;
      cfpc_pkg::REG_STOP_HIGH:  markers.stop_high  = value;
      cfpc_pkg::REG_STOP_LOW:   markers.stop_low   = value;
      default: ;
    endcase
  endtask

  task automatic program_markers(input logic [cfpc_pkg::BYTE_W-1:0] sh,
                                 input logic [cfpc_pkg::BYTE_W-1:0] sl,
                                 input logic [cfpc_pkg::BYTE_W-1:0] th,
                                 input logic [cfpc_pkg::BYTE_W-1:0] tl);
    write_marker(cfpc_pkg::REG_START_HIGH, sh);
    write_marker(cfpc_pkg::REG_START_LOW, sl);
    write_marker(cfpc_pkg::REG_STOP_HIGH, th);
    write_marker(cfpc_pkg::REG_STOP_LOW, tl);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Stimulus. The directed part runs with the reset markers, all zero.
  initial begin
    markers     = '0;
    p_phase     = cfpc_pkg::PH_IDLE;
    p_pos       = '0;
    p_len       = '0;
    p_cmd       = '0;
    p_csum      = '0;
    p_csum_ok   = 1'b0;
    p_stop_h_ok = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Loose byte while idle is dropped; a wrong first start byte is rejected.
    push_rx(8'hFF, 1'b0);
    push_rx(8'h5A, 1'b1);
    // Empty frame: the checksum follows the length bytes directly.
    queue_frame(8'hFF, 16'd0, FLAW_NONE);
    // One payload byte with both the checksum and the stop marker wrong.
    queue_frame(8'h00, 16'd1, FLAW_STOP_SUM);
    // An open frame abandoned by a new first byte, which opens a frame with
    // the largest length, rejected as too long.
    push_rx(8'h00, 1'b1);
    push_rx(8'h00, 1'b0);
    queue_frame(8'h81, 16'hFFFF, FLAW_NONE);
    // Wrong second start byte.
    push_rx(8'h00, 1'b1);
    push_rx(8'hFF, 1'b0);
    settle();

    for (int setting = 1; setting <= 5; setting++) begin
      case (setting)
        1: program_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        2: program_markers(8'h00, 8'h00, 8'h00, 8'h00);
        default: program_markers(cfpc_pkg::BYTE_W'($urandom), cfpc_pkg::BYTE_W'($urandom),
                                 cfpc_pkg::BYTE_W'($urandom), cfpc_pkg::BYTE_W'($urandom));
      endcase
      if (setting == 3) begin
        // The largest accepted length opens a payload, and the frame is then
        // abandoned by the next first byte; one more is rejected as too long.
        push_rx(markers.start_high, 1'b1);
        push_rx(markers.start_low, 1'b0);
        push_rx(cfpc_pkg::BYTE_W'($urandom), 1'b0);
        push_rx(cfpc_pkg::BYTE_W'(cfpc_pkg::MAX_PAYLOAD >> 8), 1'b0);
        push_rx(cfpc_pkg::BYTE_W'(cfpc_pkg::MAX_PAYLOAD), 1'b0);
        repeat (4) push_rx(cfpc_pkg::BYTE_W'($urandom), 1'b0);
        queue_frame(cfpc_pkg::BYTE_W'($urandom), cfpc_pkg::LEN_W'(cfpc_pkg::MAX_PAYLOAD + 1),
                    FLAW_NONE);
      end
      queue_random_traffic(90);
      // A rejected first byte leaves the parser idle before markers change.
      push_rx(~markers.start_high, 1'b1);
      settle();
    end

    $display("Sent %0d bytes in %0d frames plus loose bytes over %0d marker settings.",
             bytes_sent, frames_built, settings_used);
    $display("Checked %0d payload bytes; verdicts %0d ok, %0d bad start, %0d too long,",
             payloads_seen, status_seen[cfpc_pkg::ST_OK],
             status_seen[cfpc_pkg::ST_BAD_START], status_seen[cfpc_pkg::ST_TOO_LONG]);
    $display("%0d bad stop and %0d bad checksum.",
             status_seen[cfpc_pkg::ST_BAD_STOP], status_seen[cfpc_pkg::ST_BAD_SUM]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #(5_000_000);
    $display("Timeout with %0d bytes waiting and %0d results outstanding.",
             rx_backlog.size(), results_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
hdl/cfpc_pkg.sv
hdl/cfpc_cfg.sv
hdl/cfpc_parser.sv
hdl/checksum_framed_packet_checker.sv
bench/checksum_framed_packet_checker_test.sv
